### hdl/sed_pkg.sv
// Package for the slider EMA / deadband unit: widths, register codes,
// reset values, sequencer states and the status structs of the serial units.
// No dependencies.
`default_nettype none

package sed_pkg;

	// Field and state widths
	localparam int SMP_W   = 12;             // raw converter reading
	localparam int FRAC_W  = 8;              // fraction bits of the average
	localparam int AVG_W   = SMP_W + FRAC_W; // Q12.8 average
	localparam int POS_W   = 8;              // slider position
	localparam int ALPHA_W = 9;              // Q1.8 weight, up to 1.0
	localparam int DIFF_W  = AVG_W + 1;      // signed sample minus average
	localparam int ACC_W   = DIFF_W + 2;     // serial product accumulator

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE   = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 9'd26;
	localparam logic [SMP_W-1:0]   FULL_SCALE_RST = 12'd4095;
	localparam logic [POS_W-1:0]   MIN_MOVE_RST   = 8'd2;

	// Alpha of exactly 1.0 in Q1.8
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'h100;
	// Top of the position range
	localparam logic [POS_W-1:0]   POS_SPAN  = 8'hFF;
	// Mask that rounds a position down to even
	localparam logic [POS_W-1:0]   EVEN_MASK = 8'hFE;

	// Serial step counts: one per alpha bit, one per quotient bit plus
	// the overflow check
	localparam int MUL_STEPS = ALPHA_W;
	localparam int DIV_STEPS = POS_W + 1;
	localparam int CNT_W     = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_AVG,
		ST_SCALE,
		ST_DIV,
		ST_DECIDE
	} sed_state_t;

	// Serial multiplier status
	typedef struct packed {
		logic                     done;
		logic signed [ACC_W-1:0]  delta;  // floor(alpha * diff / 256)
	} sed_mul_res_t;

	// Serial divider status
	typedef struct packed {
		logic             done;
		logic             sat;   // quotient would exceed the position span
		logic [POS_W-1:0] quot;
	} sed_div_res_t;

endpackage

`default_nettype wire

### hdl/sed_mul.sv
// Serial-parallel multiplier for the EMA update: one alpha bit per cycle,
// LSB first, accumulator shifted right so the product comes out >> 8.
// Depends on sed_pkg.
`default_nettype none

module sed_mul
	import sed_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire        [ALPHA_W-1:0]  alpha,
	input  wire signed [DIFF_W-1:0]   diff,
	output sed_mul_res_t              res
);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [ALPHA_W-1:0]       a_q;
	logic signed [DIFF_W-1:0] d_q;
	logic signed [ACC_W-1:0]  hi_q;
	logic signed [ACC_W-1:0]  sum;
	logic                     last;

	// add the partial product for the current alpha bit
	always_comb begin
		sum  = hi_q + (a_q[0] ? ACC_W'(d_q) : '0);
		last = (cnt_q == CNT_W'(MUL_STEPS - 1));
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; the top alpha bit weighs 256, so no shift after it
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= alpha;
			d_q  <= diff;
			hi_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q >> 1;
			if (last)
				hi_q <= sum;
			else
				hi_q <= sum >>> 1;
		end
	end

	assign res.done  = done_q;
	assign res.delta = hi_q;

endmodule

`default_nettype wire

### hdl/sed_div.sv
// Restoring divider for the position scale: value*255 / full_scale,
// one quotient bit per cycle after an overflow check against 256*full_scale.
// Depends on sed_pkg.
`default_nettype none

module sed_div
	import sed_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [SMP_W-1:0]    value,
	input  wire  [SMP_W-1:0]    full_scale,
	output sed_div_res_t        res
);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [AVG_W-1:0]   rem_q;
	logic [AVG_W-1:0]   dvs_q;
	logic               sat_q;
	logic [POS_W-1:0]   quot_q;
	logic               ge;
	logic               last;

	// trial compare against the shifted divisor
	always_comb begin
		ge   = (rem_q >= dvs_q);
		last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator value*255 = (value << 8) - value; first step only flags overflow
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {value, {FRAC_W{1'b0}}} - AVG_W'(value);
			dvs_q  <= {full_scale, {FRAC_W{1'b0}}};
			sat_q  <= 1'b0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvs_q <= dvs_q >> 1;
			if (cnt_q == '0) begin
				sat_q <= ge;
			end else begin
				quot_q <= {quot_q[POS_W-2:0], ge};
				if (ge)
					rem_q <= rem_q - dvs_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quot = quot_q;

endmodule

`default_nettype wire

### hdl/slider_ema_deadband_unit.sv
// Slider EMA / deadband unit: top level with sequencer, per-channel state,
// configuration registers and output register.
// Depends on sed_pkg, sed_mul and sed_div.
//
// Usage:
//   Input channel (in_valid / in_stall, fields channel, sample) takes one
//   raw reading per item. Output channel (out_valid / out_stall, fields
//   out_channel, position, moved) returns one result item per input item.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
//   always taken; index 0 alpha, 1 full scale, 2 min move.
//   One item is processed at a time. A primed channel goes from acceptance
//   to the result register through the serial alpha multiply, one step to
//   add the update, one step to load the divider, the bit-serial divide by
//   full scale and one decide step. The first item of a channel skips the
//   multiply and the update. The next item is accepted the cycle after the
//   result is registered, even while that result still waits. A stalled
//   result holds in the output register and the unit waits in its decide
//   step until it frees. Reset clears all averages, reported positions and
//   primed flags and loads the register defaults; items are taken right after.
`default_nettype none

module slider_ema_deadband_unit
	import sed_pkg::*;
#(
	parameter int NUM_CHANNELS = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// input items
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire                    channel,
	input  wire  [SMP_W-1:0]       sample,
	// result items
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   out_channel,
	output logic [POS_W-1:0]       position,
	output logic                   moved,
	// configuration writes
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	sed_state_t state_q, state_nxt;

	// configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [SMP_W-1:0]   full_scale_q;
	logic [POS_W-1:0]   min_move_q;

	// per-channel state
	logic [AVG_W-1:0]   avg_q    [NUM_CHANNELS];
	logic [POS_W-1:0]   rep_q    [NUM_CHANNELS];
	logic               primed_q [NUM_CHANNELS];

	// latched item and its channel state
	logic               ch_q;
	logic [SMP_W-1:0]   smp_q;
	logic               inrange_q;
	logic               primed_sel_q;
	logic [AVG_W-1:0]   avg_sel_q;
	logic [POS_W-1:0]   rep_sel_q;
	logic [AVG_W-1:0]   avg_new_q;

	// output register
	logic               out_valid_q;
	logic               out_ch_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_moved_q;

	logic               accept;
	logic               out_free;
	logic               inrange_rd;
	logic               primed_rd;
	logic [AVG_W-1:0]   avg_rd;
	logic [POS_W-1:0]   rep_rd;
	logic               mul_start;
	logic               div_start;
	logic               load_out;
	logic [ALPHA_W-1:0] alpha_eff;
	logic signed [DIFF_W-1:0] diff;
	logic [SMP_W-1:0]   div_value;
	logic [ACC_W-1:0]   avg_sum;
	logic [POS_W-1:0]   cand;
	logic [POS_W-1:0]   pos_dist;
	logic               is_move;
	logic [POS_W-1:0]   pos_new;
	sed_mul_res_t       mul_res;
	sed_div_res_t       div_res;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// read the addressed channel's state
	always_comb begin
		inrange_rd = (32'(channel) < 32'(NUM_CHANNELS));
		primed_rd  = 1'b0;
		avg_rd     = '0;
		rep_rd     = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (32'(channel) == 32'(i)) begin
				primed_rd = primed_q[i];
				avg_rd    = avg_q[i];
				rep_rd    = rep_q[i];
			end
		end
	end

	// operands of the serial units
	always_comb begin
		alpha_eff = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
		diff      = DIFF_W'({sample, {FRAC_W{1'b0}}}) - DIFF_W'(avg_rd);
		div_value = primed_sel_q ? avg_new_q[AVG_W-1:FRAC_W] : smp_q;
		avg_sum   = ACC_W'(avg_sel_q) + mul_res.delta;
	end

	// candidate position and deadband test
	always_comb begin
		cand     = ~(div_res.sat ? POS_SPAN : div_res.quot);
		pos_dist = (cand >= rep_sel_q) ? (cand - rep_sel_q) : (rep_sel_q - cand);
		is_move  = (pos_dist >= min_move_q);
		priority if (!inrange_q)
			pos_new = '0;
		else if (!primed_sel_q)
			pos_new = cand & EVEN_MASK;
		else if (is_move)
			pos_new = cand;
		else
			pos_new = rep_sel_q;
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (!inrange_rd)
						state_nxt = ST_DECIDE;
					else if (primed_rd)
						state_nxt = ST_MUL;
					else
						state_nxt = ST_SCALE;
				end
			end
			ST_MUL: begin
				if (mul_res.done)
					state_nxt = ST_AVG;
			end
			ST_AVG:    state_nxt = ST_SCALE;
			ST_SCALE:  state_nxt = ST_DIV;
			ST_DIV: begin
				if (div_res.done)
					state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mul_start = (state_q == ST_IDLE) && accept && inrange_rd && primed_rd;
		div_start = (state_q == ST_SCALE);
		load_out  = (state_q == ST_DECIDE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= ALPHA_RST;
			full_scale_q <= FULL_SCALE_RST;
			min_move_q   <= MIN_MOVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EMA_ALPHA:  alpha_q      <= cfg_data[ALPHA_W-1:0];
				CFG_FULL_SCALE: full_scale_q <= cfg_data[SMP_W-1:0];
				CFG_MIN_MOVE:   min_move_q   <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// latch the item and the state of its channel
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q         <= channel;
			smp_q        <= sample;
			inrange_q    <= inrange_rd;
			primed_sel_q <= primed_rd;
			avg_sel_q    <= avg_rd;
			rep_sel_q    <= rep_rd;
		end
		if (state_q == ST_AVG)
			avg_new_q <= avg_sum[AVG_W-1:0];
	end

	// per-channel state update when the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				avg_q[i]    <= '0;
				rep_q[i]    <= '0;
				primed_q[i] <= 1'b0;
			end
		end else if (load_out && inrange_q) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (32'(ch_q) == 32'(i)) begin
					primed_q[i] <= 1'b1;
					rep_q[i]    <= pos_new;
					avg_q[i]    <= primed_sel_q ? avg_new_q : {smp_q, {FRAC_W{1'b0}}};
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q    <= ch_q;
			out_pos_q   <= pos_new;
			out_moved_q <= inrange_q && primed_sel_q && is_move;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign position    = out_pos_q;
	assign moved       = out_moved_q;

	sed_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.alpha  (alpha_eff),
		.diff   (diff),
		.res    (mul_res)
	);

	sed_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.value      (div_value),
		.full_scale (full_scale_q),
		.res        (div_res)
	);

endmodule

`default_nettype wire

### hdl/sed_checker.sv
// Port-level checker for the slider EMA / deadband unit, bound to the top.
// Depends on sed_pkg and slider_ema_deadband_unit.
`default_nettype none

module sed_checker
	import sed_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire               out_channel,
	input wire [POS_W-1:0]   position,
	input wire               moved,
	input wire               cfg_valid,
	input wire               cfg_ready
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_channel)
			&& $stable(position) && $stable(moved))
		else $error("stalled result changed");

	// one item at a time: the unit is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while busy");

	// a fresh result only appears while an item is in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind slider_ema_deadband_unit sed_checker u_sed_checker (.*);

`default_nettype wire

### tb/sv/slider_ema_deadband_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for slider_ema_deadband_unit. Drives readings on both sliders and checks every
// result item against a predictor of the smoothing, scaling and deadband logic.
// Depends on sed_pkg and the unit's RTL.

module slider_ema_deadband_unit_tb;
	import sed_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 110;
	localparam int SMP_MAX       = (1 << SMP_W) - 1;
	// index past the last register, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic             ch;
		logic [SMP_W-1:0] smp;
	} reading_t;

	typedef struct {
		logic             ch;
		logic [POS_W-1:0] pos;
		logic             mv;
	} slider_result_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// Clock, reset and block ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  channel = 1'b0;
	logic [SMP_W-1:0]      sample = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  out_channel;
	logic [POS_W-1:0]      position;
	logic                  moved;
	logic                  cfg_ready;

	// Predictor copy of the registers and per-slider state
	logic [ALPHA_W-1:0] alpha_reg = ALPHA_RST;
	logic [SMP_W-1:0]   scale_reg = FULL_SCALE_RST;
	logic [POS_W-1:0]   deadband_reg = MIN_MOVE_RST;
	logic [AVG_W-1:0]   avg_q8 [2] = '{default: '0};
	logic [POS_W-1:0]   shown_pos [2] = '{default: '0};
	logic               primed_ch [2] = '{default: 1'b0};

	reading_t       readings_todo [$];
	slider_result_t positions_due [$];
	reg_write_t     reg_writes_todo [$];

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int moves_seen = 0;
	int reg_writes_done = 0;
	int idle_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_hold = 0;
	stall_mode_t stall_mode = STALL_NONE;

	slider_ema_deadband_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.position    (position),
		.moved       (moved),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Scale a whole reading to 0..255 against full scale, clamp, invert
	function automatic logic [POS_W-1:0] map_to_position(input logic [SMP_W-1:0] level);
		logic [31:0] scaled;
		if (scale_reg == '0) begin
			scaled = 32'(POS_SPAN);
		end else begin
			scaled = (32'(level) * 32'(POS_SPAN)) / 32'(scale_reg);
			if (scaled > 32'(POS_SPAN))
				scaled = 32'(POS_SPAN);
		end
		return POS_SPAN - scaled[POS_W-1:0];
	endfunction

	// Advance one slider by one reading and return the result it must produce
	function automatic slider_result_t track_reading(input reading_t r);
		logic [ALPHA_W-1:0] a;
		logic [63:0]        acc;
		logic [POS_W-1:0]   cand;
		logic [POS_W-1:0]   step;
		slider_result_t     res;
		res.ch = r.ch;
		res.mv = 1'b0;
		if (!primed_ch[r.ch]) begin
			// first reading seeds the average, position rounded down to even
			primed_ch[r.ch] = 1'b1;
			avg_q8[r.ch] = {r.smp, {FRAC_W{1'b0}}};
			shown_pos[r.ch] = map_to_position(r.smp) & EVEN_MASK;
		end else begin
			a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
			acc = 64'(a) * (64'(r.smp) << FRAC_W)
				+ (64'(ALPHA_ONE) - 64'(a)) * 64'(avg_q8[r.ch]);
			avg_q8[r.ch] = acc[FRAC_W +: AVG_W];
			cand = map_to_position(avg_q8[r.ch][AVG_W-1 -: SMP_W]);
			step = (cand >= shown_pos[r.ch]) ? cand - shown_pos[r.ch] : shown_pos[r.ch] - cand;
			if (step >= deadband_reg) begin
				shown_pos[r.ch] = cand;
				res.mv = 1'b1;
			end
		end
		res.pos = shown_pos[r.ch];
		return res;
	endfunction

	// Reading driver: bursts of random length with random gaps
	always @(posedge clk) begin : reading_drive
		reading_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				r.ch = channel;
				r.smp = sample;
				positions_due.push_back(track_reading(r));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (readings_todo.size() != 0) begin
					r = readings_todo.pop_front();
					in_valid <= 1'b1;
					channel <= r.ch;
					sample <= r.smp;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver, also keeps the predictor's register copy
	always @(posedge clk) begin : reg_drive
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_writes_done++;
				case (cfg_index)
					CFG_EMA_ALPHA:  alpha_reg = cfg_data[ALPHA_W-1:0];
					CFG_FULL_SCALE: scale_reg = cfg_data[SMP_W-1:0];
					CFG_MIN_MOVE:   deadband_reg = cfg_data[POS_W-1:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes_todo.size() != 0) begin
					w = reg_writes_todo.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall pattern
	always @(posedge clk) begin : result_check
		slider_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (moved)
					moves_seen++;
				if (positions_due.size() == 0) begin
					$display("%0t: result with none due: out_channel=%0d position=%0d moved=%0d",
						$time, out_channel, position, moved);
					errors++;
				end else begin
					want = positions_due.pop_front();
					if (out_channel !== want.ch) begin
						$display("%0t: out_channel expected %0d got %0d", $time, want.ch, out_channel);
						errors++;
					end
					if (position !== want.pos) begin
						$display("%0t: position expected %0d got %0d", $time, want.pos, position);
						errors++;
					end
					if (moved !== want.mv) begin
						$display("%0t: moved expected %0d got %0d", $time, want.mv, moved);
						errors++;
					end
				end
			end
			// switch to a random stall mode whenever the hold count runs out
			if (stall_hold > 0) begin
				stall_hold--;
			end else begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_hold = $urandom_range(50, 300);
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= stall_hold[2];
			endcase
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	task automatic queue_reading(input logic ch, input logic [SMP_W-1:0] smp);
		reading_t r;
		r.ch = ch;
		r.smp = smp;
		readings_todo.push_back(r);
	endtask

	// Wait until nothing is queued, in flight or due; checked at the falling edge
	task automatic wait_idle();
		do
			@(negedge clk);
		while (readings_todo.size() != 0 || in_valid || positions_due.size() != 0
			|| reg_writes_todo.size() != 0 || cfg_valid);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		reg_write_t w;
		w.idx = idx;
		w.data = data[CFG_DATA_W-1:0];
		wait_idle();
		reg_writes_todo.push_back(w);
		wait_idle();
	endtask

	initial begin : stimulus
		int  ch_target [2];
		int  s;
		int  pick;
		logic ch;
		ch_target[0] = SMP_MAX / 2;
		ch_target[1] = SMP_MAX / 2;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: priming (odd position rounds down, even stays) and slow tracking
		queue_reading(1'b0, 12'd0);
		queue_reading(1'b1, 12'hFFF);
		queue_reading(1'b0, 12'hFFF);
		queue_reading(1'b0, 12'hFFF);
		queue_reading(1'b1, 12'd0);
		queue_reading(1'b1, 12'd0);
		queue_reading(1'b0, 12'h800);
		queue_reading(1'b1, 12'h7FF);

		// No smoothing and no deadband: every reading is a move, even an unchanged one
		write_reg(CFG_EMA_ALPHA, int'(ALPHA_ONE));
		write_reg(CFG_MIN_MOVE, 0);
		queue_reading(1'b0, 12'hFFF);
		queue_reading(1'b0, 12'd0);
		queue_reading(1'b1, 12'd1);
		queue_reading(1'b1, 12'hFFE);
		queue_reading(1'b0, 12'hAAA);
		queue_reading(1'b1, 12'h555);
		queue_reading(1'b0, 12'hAAA);

		// Zero alpha holds the average
		write_reg(CFG_EMA_ALPHA, 0);
		queue_reading(1'b0, 12'hFFF);
		queue_reading(1'b1, 12'd0);

		// Alpha above one acts as one; zero full scale pins the position at 0
		write_reg(CFG_EMA_ALPHA, SMP_MAX);
		write_reg(CFG_FULL_SCALE, 0);
		queue_reading(1'b0, 12'd123);
		queue_reading(1'b1, 12'hFFF);

		// Full scale of one: any nonzero reading reaches the top of the range; widest deadband
		write_reg(CFG_FULL_SCALE, 1);
		write_reg(CFG_MIN_MOVE, SMP_MAX);
		queue_reading(1'b0, 12'd0);
		queue_reading(1'b0, 12'd1);
		queue_reading(1'b1, 12'hFFF);

		// Write to an unused index must change nothing
		write_reg(CFG_SPARE, SMP_MAX);
		queue_reading(1'b0, 12'd2000);
		wait_idle();

		// Random phases, each under its own settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: write_reg(CFG_EMA_ALPHA, 0);
				1: write_reg(CFG_EMA_ALPHA, 1);
				2: write_reg(CFG_EMA_ALPHA, int'(ALPHA_ONE));
				3: write_reg(CFG_EMA_ALPHA, $urandom_range(257, SMP_MAX));
				default: write_reg(CFG_EMA_ALPHA, $urandom_range(2, 255));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(CFG_FULL_SCALE, 0);
				1: write_reg(CFG_FULL_SCALE, 1);
				2: write_reg(CFG_FULL_SCALE, SMP_MAX);
				3: write_reg(CFG_FULL_SCALE, $urandom_range(1, 64));
				default: write_reg(CFG_FULL_SCALE, $urandom_range(1, SMP_MAX));
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(CFG_MIN_MOVE, 0);
				1: write_reg(CFG_MIN_MOVE, 1);
				2: write_reg(CFG_MIN_MOVE, 255);
				3: write_reg(CFG_MIN_MOVE, $urandom_range(256, SMP_MAX));
				default: write_reg(CFG_MIN_MOVE, $urandom_range(0, 16));
			endcase
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_SPARE, $urandom_range(0, SMP_MAX));

			// readings near a per-slider target, uniform noise, some jumps and extremes
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				ch = 1'($urandom_range(0, 1));
				pick = $urandom_range(0, 9);
				if (pick <= 1) begin
					s = ch_target[ch] + int'($urandom_range(0, 16)) - 8;
				end else if (pick <= 3) begin
					s = ch_target[ch] + int'($urandom_range(0, 96)) - 48;
				end else if (pick == 4) begin
					case ($urandom_range(0, 3))
						0: s = 0;
						1: s = SMP_MAX;
						2: s = int'(scale_reg);
						default: s = int'(scale_reg) - 1;
					endcase
				end else if (pick == 5) begin
					ch_target[ch] = $urandom_range(0, SMP_MAX);
					s = ch_target[ch];
				end else begin
					s = $urandom_range(0, SMP_MAX);
				end
				if (s < 0)
					s = 0;
				else if (s > SMP_MAX)
					s = SMP_MAX;
				queue_reading(ch, s[SMP_W-1:0]);
			end
			wait_idle();
		end

		// Let any stray result show up before closing
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (positions_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, positions_due.size());
			errors++;
		end
		$display("Ran %0d readings over both sliders: %0d results, %0d moves, %0d register writes.",
			items_sent, results_seen, moves_seen, reg_writes_done);
		$display("Covered priming, alpha extremes, zero and tiny full scale, deadband 0..255, %0d errors.",
			errors);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/sed_pkg.sv
hdl/sed_mul.sv
hdl/sed_div.sv
hdl/slider_ema_deadband_unit.sv
hdl/sed_checker.sv
tb/sv/slider_ema_deadband_unit_tb.sv
